// ----- hdl/pcig_pkg.sv -----
// ----------------------------------------------------------------------------
// pcig_pkg
// Shared types and constants of the payload combination index generator:
// register indexes, mode codes, configuration, state and result records.
// ----------------------------------------------------------------------------
package pcig_pkg;

  localparam int MaxPositions = 4;
  localparam int NumSets      = 4;
  localparam int IndexWidth   = 16;
  localparam int CountWidth   = 16;
  localparam int PosWidth     = 3;
  localparam int ModeWidth    = 2;
  localparam int RegIdxWidth  = 3;
  localparam int DataWidth    = 16;

  localparam logic [ModeWidth-1:0] ModeSniper  = 2'd0;
  localparam logic [ModeWidth-1:0] ModeRam     = 2'd1;
  localparam logic [ModeWidth-1:0] ModePitch   = 2'd2;
  localparam logic [ModeWidth-1:0] ModeCluster = 2'd3;

  localparam logic [RegIdxWidth-1:0] RegAttackMode    = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegPositionCount = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegResultLimit   = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegSetSize0      = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegSetSize1      = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegSetSize2      = 3'd5;
  localparam logic [RegIdxWidth-1:0] RegSetSize3      = 3'd6;

  typedef struct packed {
    logic [ModeWidth-1:0]                  mode;
    logic [PosWidth-1:0]                   pos_count;
    logic [CountWidth-1:0]                 limit;
    logic [NumSets-1:0][IndexWidth-1:0]    size;
  } cfg_t;

  typedef struct packed {
    logic [MaxPositions-1:0][IndexWidth-1:0] digit;
    logic [PosWidth-1:0]                     sweep;
    logic [CountWidth-1:0]                   emitted;
    logic                                    finished;
  } state_t;

  typedef struct packed {
    logic                               valid_res;
    logic [NumSets-1:0][IndexWidth-1:0] index;
    logic [NumSets-1:0]                 mask;
    logic                               last;
  } res_t;

endpackage

// ----- hdl/payload_combination_index_generator.sv -----
// ----------------------------------------------------------------------------
// payload_combination_index_generator
// A request beat passes from the input register into the result register,
// one beat per cycle unless out_ready stalls it; the odometer state updates
// in the cycle a request moves from the input register into the result one.
// Reset: synchronous; clears configuration, odometer state and valid flags,
// leaving the run at its first combination.
// ----------------------------------------------------------------------------
module payload_combination_index_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_valid_res,
  output logic [pcig_pkg::IndexWidth-1:0]    out_index_pos0,
  output logic [pcig_pkg::IndexWidth-1:0]    out_index_pos1,
  output logic [pcig_pkg::IndexWidth-1:0]    out_index_pos2,
  output logic [pcig_pkg::IndexWidth-1:0]    out_index_pos3,
  output logic [pcig_pkg::NumSets-1:0]       out_default_mask,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [pcig_pkg::RegIdxWidth-1:0]   cfg_index,
  input  logic [pcig_pkg::DataWidth-1:0]     cfg_wdata
);

  pcig_pkg::cfg_t   cfg;
  pcig_pkg::state_t state_r;
  pcig_pkg::state_t state_nxt;
  pcig_pkg::res_t   res_nxt;
  pcig_pkg::res_t   res_r;
  logic             stage_valid_r;
  logic             restart_r;
  logic             out_valid_r;
  logic             advance;

  pcig_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  pcig_step u_step (
    .cfg       (cfg),
    .state_cur (state_r),
    .restart   (restart_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= '0;
    end else begin
      if (in_ready) stage_valid_r <= in_valid;
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) restart_r <= in_restart;
    if (advance) res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = res_r.valid_res;
  assign out_index_pos0   = res_r.index[0];
  assign out_index_pos1   = res_r.index[1];
  assign out_index_pos2   = res_r.index[2];
  assign out_index_pos3   = res_r.index[3];
  assign out_default_mask = res_r.mask;
  assign out_last         = res_r.last;

endmodule

// ----- hdl/pcig_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pcig_cfg_regs
// Configuration register file: mode, position count, result limit and the
// four set sizes, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module pcig_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              we,
  input  logic [pcig_pkg::RegIdxWidth-1:0]  index,
  input  logic [pcig_pkg::DataWidth-1:0]    wdata,
  output pcig_pkg::cfg_t                    cfg
);

  pcig_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (we) begin
      unique case (index)
        pcig_pkg::RegAttackMode:    cfg_r.mode      <= wdata[pcig_pkg::ModeWidth-1:0];
        pcig_pkg::RegPositionCount: cfg_r.pos_count <= wdata[pcig_pkg::PosWidth-1:0];
        pcig_pkg::RegResultLimit:   cfg_r.limit     <= wdata[pcig_pkg::CountWidth-1:0];
        pcig_pkg::RegSetSize0:      cfg_r.size[0]   <= wdata[pcig_pkg::IndexWidth-1:0];
        pcig_pkg::RegSetSize1:      cfg_r.size[1]   <= wdata[pcig_pkg::IndexWidth-1:0];
        pcig_pkg::RegSetSize2:      cfg_r.size[2]   <= wdata[pcig_pkg::IndexWidth-1:0];
        pcig_pkg::RegSetSize3:      cfg_r.size[3]   <= wdata[pcig_pkg::IndexWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/pcig_step.sv -----
// ----------------------------------------------------------------------------
// pcig_step
// One enumeration step: checks the stored position against the current
// mode, forms the index tuple and default mask, and advances the odometer.
// ----------------------------------------------------------------------------
module pcig_step (
  input  pcig_pkg::cfg_t   cfg,
  input  pcig_pkg::state_t state_cur,
  input  logic             restart,
  output pcig_pkg::state_t state_nxt,
  output pcig_pkg::res_t   res
);

  pcig_pkg::state_t                      st;
  pcig_pkg::state_t                      adv;
  logic [pcig_pkg::PosWidth-1:0]         npos;
  logic [pcig_pkg::MaxPositions-1:0]     used;
  logic [pcig_pkg::MaxPositions-1:0]     nonempty;
  logic [pcig_pkg::IndexWidth-1:0]       shortest;
  logic                                  any_set;
  logic                                  bad_digit;
  logic                                  mode_ok;
  logic                                  valid;
  logic                                  adv_ok;
  logic                                  carry;
  logic                                  limit_hit;
  logic [pcig_pkg::IndexWidth:0]         d0_inc;
  logic [pcig_pkg::IndexWidth:0]         dp_inc;
  logic [pcig_pkg::PosWidth-1:0]         sweep_inc;
  logic [pcig_pkg::CountWidth-1:0]       emitted_inc;

  always_comb begin
    st = state_cur;
    if (restart) begin
      st.digit    = '0;
      st.sweep    = '0;
      st.emitted  = '0;
      st.finished = 1'b0;
    end

    npos = (cfg.pos_count > pcig_pkg::PosWidth'(pcig_pkg::MaxPositions)) ?
           pcig_pkg::PosWidth'(pcig_pkg::MaxPositions) : cfg.pos_count;

    shortest  = '0;
    any_set   = 1'b0;
    bad_digit = 1'b0;
    for (int p = 0; p < pcig_pkg::MaxPositions; p++) begin
      used[p]     = pcig_pkg::PosWidth'(p) < npos;
      nonempty[p] = cfg.size[p] != '0;
      if (used[p] && nonempty[p]) begin
        any_set = 1'b1;
        if (st.digit[p] >= cfg.size[p]) bad_digit = 1'b1;
        if (shortest == '0 || cfg.size[p] < shortest) shortest = cfg.size[p];
      end
    end

    unique case (cfg.mode)
      pcig_pkg::ModeSniper:  mode_ok = (st.sweep < npos) && (st.digit[0] < cfg.size[0]);
      pcig_pkg::ModeRam:     mode_ok = st.digit[0] < cfg.size[0];
      pcig_pkg::ModePitch:   mode_ok = st.digit[0] < shortest;
      pcig_pkg::ModeCluster: mode_ok = any_set && !bad_digit;
      default:               mode_ok = 1'b0;
    endcase

    valid = !st.finished && (npos != '0) && (cfg.limit != '0) &&
            (st.emitted < cfg.limit) && mode_ok;

    res = '0;
    if (valid) begin
      res.valid_res = 1'b1;
      for (int p = 0; p < pcig_pkg::NumSets; p++) begin
        if (used[p]) begin
          unique case (cfg.mode)
            pcig_pkg::ModeSniper:  res.mask[p] = pcig_pkg::PosWidth'(p) != st.sweep;
            pcig_pkg::ModeRam:     res.mask[p] = 1'b0;
            default:               res.mask[p] = !nonempty[p];
          endcase
          if (!res.mask[p]) begin
            res.index[p] = (cfg.mode == pcig_pkg::ModeCluster) ? st.digit[p] : st.digit[0];
          end
        end
      end
    end

    adv       = st;
    adv_ok    = 1'b0;
    carry     = 1'b1;
    dp_inc    = '0;
    d0_inc    = {1'b0, st.digit[0]} + 1'b1;
    sweep_inc = st.sweep + 1'b1;
    unique case (cfg.mode)
      pcig_pkg::ModeSniper: begin
        if (d0_inc < {1'b0, cfg.size[0]}) begin
          adv.digit[0] = d0_inc[pcig_pkg::IndexWidth-1:0];
          adv_ok       = 1'b1;
        end else begin
          adv.digit[0] = '0;
          adv.sweep    = sweep_inc;
          adv_ok       = sweep_inc < npos;
        end
      end
      pcig_pkg::ModeRam: begin
        adv.digit[0] = d0_inc[pcig_pkg::IndexWidth-1:0];
        adv_ok       = d0_inc < {1'b0, cfg.size[0]};
      end
      pcig_pkg::ModePitch: begin
        adv.digit[0] = d0_inc[pcig_pkg::IndexWidth-1:0];
        adv_ok       = d0_inc < {1'b0, shortest};
      end
      default: begin
        for (int p = pcig_pkg::MaxPositions - 1; p >= 0; p--) begin
          dp_inc = {1'b0, st.digit[p]} + 1'b1;
          if (carry && used[p] && nonempty[p]) begin
            if (dp_inc < {1'b0, cfg.size[p]}) begin
              adv.digit[p] = dp_inc[pcig_pkg::IndexWidth-1:0];
              carry        = 1'b0;
            end else begin
              adv.digit[p] = '0;
            end
          end
        end
        adv_ok = !carry;
      end
    endcase

    emitted_inc = st.emitted + 1'b1;
    limit_hit   = emitted_inc >= cfg.limit;

    state_nxt = st;
    if (!valid) begin
      state_nxt.finished = 1'b1;
    end else begin
      if (!limit_hit) state_nxt = adv;
      state_nxt.emitted  = emitted_inc;
      state_nxt.finished = limit_hit || !adv_ok;
    end
    res.last = valid && state_nxt.finished;
  end

endmodule

// ----- bench/payload_combination_index_generator_tb.sv -----
// ----------------------------------------------------------------------------
// payload_combination_index_generator_tb
// Drives request beats through the combination generator under every attack
// mode and compares each result beat, field by field, with an in-bench
// odometer predictor or a typed value. A directed table opens the run;
// random register settings, restarts, stalls and long result hold-offs follow.
// ----------------------------------------------------------------------------
module payload_combination_index_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int ShowLimit  = 10;
  localparam int NumPhases  = 12;
  localparam int PhaseBeats = 165;
  localparam logic [pcig_pkg::RegIdxWidth-1:0] RegSpare = 3'd7;

  typedef enum logic {RowWrite, RowBeat} row_kind_t;

  typedef struct {
    row_kind_t                           kind;
    logic [pcig_pkg::RegIdxWidth-1:0]    addr;
    logic [pcig_pkg::DataWidth-1:0]      data;
    logic                                restart;
    bit                                  typed;
    pcig_pkg::res_t                      want;
  } plan_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_restart;
  logic                             out_valid;
  logic                             out_ready;
  logic                             out_valid_res;
  logic [pcig_pkg::IndexWidth-1:0]  out_index_pos0;
  logic [pcig_pkg::IndexWidth-1:0]  out_index_pos1;
  logic [pcig_pkg::IndexWidth-1:0]  out_index_pos2;
  logic [pcig_pkg::IndexWidth-1:0]  out_index_pos3;
  logic [pcig_pkg::NumSets-1:0]     out_default_mask;
  logic                             out_last;
  logic                             cfg_we;
  logic [pcig_pkg::RegIdxWidth-1:0] cfg_index;
  logic [pcig_pkg::DataWidth-1:0]   cfg_wdata;

  payload_combination_index_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_index_pos0   (out_index_pos0),
    .out_index_pos1   (out_index_pos1),
    .out_index_pos2   (out_index_pos2),
    .out_index_pos3   (out_index_pos3),
    .out_default_mask (out_default_mask),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  logic [pcig_pkg::ModeWidth-1:0]  reg_mode = '0;
  logic [pcig_pkg::PosWidth-1:0]   reg_positions = '0;
  logic [pcig_pkg::CountWidth-1:0] reg_limit = '0;
  logic [pcig_pkg::IndexWidth-1:0] reg_set_size [pcig_pkg::NumSets] = '{default: '0};

  logic [pcig_pkg::IndexWidth-1:0] odo_digit [pcig_pkg::MaxPositions] = '{default: '0};
  logic [pcig_pkg::PosWidth-1:0]   sweep_pos = '0;
  logic [pcig_pkg::CountWidth-1:0] emit_count = '0;
  bit                              run_over = 1'b0;

  pcig_pkg::res_t pending_combos[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_ask = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned set_len(int p);
    return (p < pcig_pkg::NumSets) ? reg_set_size[p] : 0;
  endfunction

  function automatic int used_positions();
    return (reg_positions > pcig_pkg::MaxPositions) ? pcig_pkg::MaxPositions : reg_positions;
  endfunction

  function automatic int unsigned shortest_len(int npos);
    int unsigned best;
    int unsigned n;
    best = 0;
    for (int p = 0; p < npos; p++) begin
      n = set_len(p);
      if (n != 0 && (best == 0 || n < best)) best = n;
    end
    return best;
  endfunction

  function automatic bit combo_exists(int npos);
    bit any;
    int unsigned n;
    any = 1'b0;
    if (npos == 0 || reg_limit == 0 || emit_count >= reg_limit) return 1'b0;
    case (reg_mode)
      pcig_pkg::ModeSniper: return sweep_pos < npos && odo_digit[0] < set_len(0);
      pcig_pkg::ModeRam:    return odo_digit[0] < set_len(0);
      pcig_pkg::ModePitch:  return odo_digit[0] < shortest_len(npos);
      default: begin
        for (int p = 0; p < npos; p++) begin
          n = set_len(p);
          if (n != 0) begin
            any = 1'b1;
            if (odo_digit[p] >= n) return 1'b0;
          end
        end
        return any;
      end
    endcase
  endfunction

  function automatic bit step_odometer(int npos);
    int unsigned n;
    case (reg_mode)
      pcig_pkg::ModeSniper: begin
        if (int'(odo_digit[0]) + 1 < set_len(0)) begin
          odo_digit[0]++;
          return 1'b1;
        end
        odo_digit[0] = '0;
        sweep_pos = sweep_pos + 1'b1;
        return sweep_pos < npos;
      end
      pcig_pkg::ModeRam: begin
        odo_digit[0]++;
        return odo_digit[0] < set_len(0);
      end
      pcig_pkg::ModePitch: begin
        odo_digit[0]++;
        return odo_digit[0] < shortest_len(npos);
      end
      default: begin
        for (int p = npos; p > 0; p--) begin
          n = set_len(p - 1);
          if (n == 0) continue;
          if (int'(odo_digit[p-1]) + 1 < n) begin
            odo_digit[p-1]++;
            return 1'b1;
          end
          odo_digit[p-1] = '0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic pcig_pkg::res_t next_combination(logic restart);
    int             npos;
    bit             dflt;
    pcig_pkg::res_t r;
    npos = used_positions();
    r = '0;
    if (restart) begin
      foreach (odo_digit[i]) odo_digit[i] = '0;
      sweep_pos = '0;
      emit_count = '0;
      run_over = 1'b0;
    end
    if (run_over || !combo_exists(npos)) begin
      run_over = 1'b1;
      return r;
    end
    for (int p = 0; p < npos; p++) begin
      case (reg_mode)
        pcig_pkg::ModeSniper: dflt = (p != sweep_pos);
        pcig_pkg::ModeRam:    dflt = 1'b0;
        default:              dflt = (set_len(p) == 0);
      endcase
      if (dflt) r.mask[p] = 1'b1;
      else r.index[p] = (reg_mode == pcig_pkg::ModeCluster) ? odo_digit[p] : odo_digit[0];
    end
    emit_count++;
    if (emit_count >= reg_limit) run_over = 1'b1;
    else if (!step_odometer(npos)) run_over = 1'b1;
    r.valid_res = 1'b1;
    r.last = run_over;
    return r;
  endfunction

  function automatic void store_reg(logic [pcig_pkg::RegIdxWidth-1:0] addr,
                                    logic [pcig_pkg::DataWidth-1:0] data);
    case (addr)
      pcig_pkg::RegAttackMode:    reg_mode = data[pcig_pkg::ModeWidth-1:0];
      pcig_pkg::RegPositionCount: reg_positions = data[pcig_pkg::PosWidth-1:0];
      pcig_pkg::RegResultLimit:   reg_limit = data;
      pcig_pkg::RegSetSize0:      reg_set_size[0] = data;
      pcig_pkg::RegSetSize1:      reg_set_size[1] = data;
      pcig_pkg::RegSetSize2:      reg_set_size[2] = data;
      pcig_pkg::RegSetSize3:      reg_set_size[3] = data;
      default: ;
    endcase
  endfunction

  function automatic string describe_combo(pcig_pkg::res_t r);
    return $sformatf("valid=%0d idx=%0d/%0d/%0d/%0d mask=%b last=%0d", r.valid_res,
                     r.index[0], r.index[1], r.index[2], r.index[3], r.mask, r.last);
  endfunction

  function automatic logic [pcig_pkg::CountWidth-1:0] pick_limit();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return pcig_pkg::CountWidth'($urandom_range(16'hFFFF));
      default: return pcig_pkg::CountWidth'($urandom_range(60, 1));
    endcase
  endfunction

  function automatic logic [pcig_pkg::IndexWidth-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return pcig_pkg::IndexWidth'($urandom_range(16'hFFFF));
      default: return pcig_pkg::IndexWidth'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic plan_row_t wr(logic [pcig_pkg::RegIdxWidth-1:0] addr,
                                   logic [pcig_pkg::DataWidth-1:0] data);
    plan_row_t r;
    r.kind = RowWrite;
    r.addr = addr;
    r.data = data;
    r.restart = 1'b0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t beat_is(logic restart, bit typed, pcig_pkg::res_t want);
    plan_row_t r;
    r.kind = RowBeat;
    r.addr = '0;
    r.data = '0;
    r.restart = restart;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic pcig_pkg::res_t zero_index_combo(logic [pcig_pkg::NumSets-1:0] mask,
                                                      logic last);
    pcig_pkg::res_t r;
    r = '0;
    r.valid_res = 1'b1;
    r.mask = mask;
    r.last = last;
    return r;
  endfunction

  task automatic write_reg(input logic [pcig_pkg::RegIdxWidth-1:0] addr,
                           input logic [pcig_pkg::DataWidth-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    store_reg(addr, data);
  endtask

  task automatic send_beat(input logic restart, input bit typed, input pcig_pkg::res_t want);
    pcig_pkg::res_t predicted;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_combination(restart);
    pending_combos.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_combos.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // result receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pcig_pkg::res_t seen;
    pcig_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      seen.valid_res = out_valid_res;
      seen.index[0] = out_index_pos0;
      seen.index[1] = out_index_pos1;
      seen.index[2] = out_index_pos2;
      seen.index[3] = out_index_pos3;
      seen.mask = out_default_mask;
      seen.last = out_last;
      if (pending_combos.size() == 0) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("unexpected result beat: %s", describe_combo(seen));
      end else begin
        want = pending_combos.pop_front();
        if (seen.valid_res !== want.valid_res || seen.index !== want.index ||
            seen.mask !== want.mask || seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= ShowLimit)
            $display("result mismatch: expected %s, got %s",
                     describe_combo(want), describe_combo(seen));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    plan_row_t                      plan[$];
    pcig_pkg::res_t                 none;
    logic                           restart;
    bit                             writing;
    logic [pcig_pkg::DataWidth-1:0] data;
    none = '0;
    writing = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 25;
    recv_idle_pct = 79;

    plan.push_back(beat_is(1'b0, 1'b1, none));
    plan.push_back(wr(pcig_pkg::RegAttackMode, pcig_pkg::DataWidth'(pcig_pkg::ModeRam)));
    plan.push_back(wr(pcig_pkg::RegPositionCount, 16'd2));
    plan.push_back(wr(pcig_pkg::RegResultLimit, 16'hFFFF));
    plan.push_back(wr(pcig_pkg::RegSetSize0, 16'd2));
    plan.push_back(beat_is(1'b1, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b1, none));
    plan.push_back(wr(pcig_pkg::RegAttackMode, pcig_pkg::DataWidth'(pcig_pkg::ModeSniper)));
    plan.push_back(wr(pcig_pkg::RegPositionCount, 16'd7));
    plan.push_back(wr(pcig_pkg::RegSetSize0, 16'd1));
    plan.push_back(wr(pcig_pkg::RegSetSize1, 16'hFFFF));
    plan.push_back(wr(pcig_pkg::RegSetSize2, 16'hFFFF));
    plan.push_back(wr(pcig_pkg::RegSetSize3, 16'hFFFF));
    plan.push_back(beat_is(1'b1, 1'b1, zero_index_combo(4'b1110, 1'b0)));
    plan.push_back(beat_is(1'b0, 1'b1, zero_index_combo(4'b1101, 1'b0)));
    plan.push_back(beat_is(1'b0, 1'b1, zero_index_combo(4'b1011, 1'b0)));
    plan.push_back(beat_is(1'b0, 1'b1, zero_index_combo(4'b0111, 1'b1)));
    plan.push_back(beat_is(1'b0, 1'b1, none));
    plan.push_back(wr(pcig_pkg::RegAttackMode, pcig_pkg::DataWidth'(pcig_pkg::ModePitch)));
    plan.push_back(wr(pcig_pkg::RegPositionCount, 16'd4));
    plan.push_back(wr(pcig_pkg::RegSetSize0, 16'd0));
    plan.push_back(wr(pcig_pkg::RegSetSize1, 16'd3));
    plan.push_back(wr(pcig_pkg::RegSetSize2, 16'd2));
    plan.push_back(beat_is(1'b1, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b0, none));
    plan.push_back(wr(pcig_pkg::RegAttackMode, pcig_pkg::DataWidth'(pcig_pkg::ModeCluster)));
    plan.push_back(wr(pcig_pkg::RegPositionCount, 16'd3));
    plan.push_back(wr(pcig_pkg::RegSetSize0, 16'd2));
    plan.push_back(wr(pcig_pkg::RegSetSize1, 16'd0));
    plan.push_back(wr(pcig_pkg::RegSetSize2, 16'd2));
    plan.push_back(wr(pcig_pkg::RegResultLimit, 16'd3));
    plan.push_back(beat_is(1'b1, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b1, none));
    plan.push_back(wr(RegSpare, 16'hA5A5));
    plan.push_back(wr(pcig_pkg::RegResultLimit, 16'd0));
    plan.push_back(beat_is(1'b1, 1'b1, none));
    plan.push_back(wr(pcig_pkg::RegResultLimit, 16'hFFFF));
    plan.push_back(beat_is(1'b1, 1'b0, none));
    plan.push_back(beat_is(1'b0, 1'b0, none));
    plan.push_back(wr(pcig_pkg::RegSetSize0, 16'd1));
    plan.push_back(beat_is(1'b0, 1'b1, none));
    plan.push_back(beat_is(1'b1, 1'b0, none));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        if (!writing) wait_for_idle();
        writing = 1'b1;
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        writing = 1'b0;
        send_beat(plan[i].restart, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_for_idle();
      send_idle_pct = (ph < 4) ? 25 : (ph < 8) ? 79 : 0;
      recv_idle_pct = (ph < 4) ? 79 : (ph < 8) ? 25 : 0;
      // every third phase keeps the run going across a partial register change
      if (ph % 3 == 2) begin
        write_reg(pcig_pkg::RegIdxWidth'(pcig_pkg::RegSetSize0 + $urandom_range(3)),
                  pick_size());
        write_reg(pcig_pkg::RegResultLimit, pick_limit());
      end else begin
        data = pcig_pkg::DataWidth'($urandom_range(3));
        if ($urandom_range(7) == 0) data |= 16'($urandom) & 16'hFFFC;
        write_reg(pcig_pkg::RegAttackMode, data);
        data = ($urandom_range(4) == 0) ? pcig_pkg::DataWidth'($urandom_range(7)) :
                                          pcig_pkg::DataWidth'($urandom_range(4, 1));
        if ($urandom_range(7) == 0) data |= 16'($urandom) & 16'hFFF8;
        write_reg(pcig_pkg::RegPositionCount, data);
        write_reg(pcig_pkg::RegResultLimit, pick_limit());
        for (int s = 0; s < pcig_pkg::NumSets; s++)
          write_reg(pcig_pkg::RegIdxWidth'(pcig_pkg::RegSetSize0 + s), pick_size());
        if ($urandom_range(3) == 0)
          write_reg(RegSpare, pcig_pkg::DataWidth'($urandom_range(16'hFFFF)));
      end
      if (ph == 1 || ph == 9) hold_ask++;
      for (int k = 0; k < PhaseBeats; k++) begin
        if (k == 0) restart = (ph % 3 != 2);
        else if (run_over) restart = ($urandom_range(3) != 0);
        else restart = ($urandom_range(39) == 0);
        send_beat(restart, 1'b0, none);
      end
    end

    wait_for_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_combos.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
